FILE: rtl/pngu_pkg.sv
// pngu_pkg: shared types, codes and the paeth predictor for the png scanline unfilter
// used by every module under rtl except pngu_row_mem; no dependencies
package pngu_pkg;

  // filter type codes carried by the first byte of each row
  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } flt_e;

  // configuration register indexes
  localparam logic [1:0] CFG_BPP       = 2'd0;
  localparam logic [1:0] CFG_ROW_BYTES = 2'd1;
  localparam logic [1:0] CFG_ROWS      = 2'd2;

  localparam int unsigned CfgDataW = 16;

  // input item
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       start_of_image;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;
  } out_item_t;

  // item handed from the control stage to the reconstruction stage
  typedef struct packed {
    logic       is_err;
    flt_e       filter;
    logic [7:0] data;
    logic       left_ok;
    logic       has_above;
    logic       row_end;
    logic       image_end;
  } tag_t;

  // paeth predictor: nearest of left, above, upper-left to left + above - upper-left
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      paeth = a;
    end else if (pb <= pc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

endpackage

FILE: rtl/pngu_row_mem.sv
// pngu_row_mem: synchronous memory holding the previous reconstructed row
// one write and one registered read per cycle; no dependencies
module pngu_row_mem #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned AddrW = 13
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [7:0]       wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [7:0]       rd_data_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/pngu_ctrl.sv
// pngu_ctrl: configuration registers and the per-byte row sequencer
// depends on pngu_pkg
module pngu_ctrl #(
  parameter int unsigned MaxRowBytes   = 8192,
  parameter int unsigned MaxPixelBytes = 4,
  parameter int unsigned AddrW         = 13,
  parameter int unsigned BppIdxW       = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [pngu_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           accept_i,
  input  pngu_pkg::in_item_t             item_i,
  output logic                           issue_o,
  output logic                           rd_en_o,
  output pngu_pkg::tag_t                 tag_o,
  output logic [AddrW-1:0]               addr_o,
  output logic [BppIdxW-1:0]             bpp_idx_o
);

  localparam int unsigned RbW  = $clog2(MaxRowBytes + 1);
  localparam int unsigned CmpW = (RbW > 14) ? RbW : 14;

  logic [2:0]         bpp_q;
  logic [13:0]        row_bytes_q;
  logic [15:0]        image_rows_q;
  logic [AddrW-1:0]   col_q, col_d;
  logic               want_q, want_d;
  logic [15:0]        rows_q, rows_d;
  pngu_pkg::flt_e     filter_q, filter_d;
  logic               halted_q, halted_d;

  logic [3:0]         bpp_eff;
  logic [CmpW-1:0]    rb_eff;
  logic               soi;
  logic [AddrW-1:0]   col_v;
  logic [15:0]        rows_v;
  logic               halt_v;
  logic               want_v;
  logic               drop;
  logic [CmpW-1:0]    col_next;
  logic               row_done;
  logic [15:0]        rows_inc;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q        <= 3'd1;
      row_bytes_q  <= 14'd1;
      image_rows_q <= 16'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pngu_pkg::CFG_BPP:       bpp_q        <= cfg_data_i[2:0];
        pngu_pkg::CFG_ROW_BYTES: row_bytes_q  <= cfg_data_i[13:0];
        pngu_pkg::CFG_ROWS:      image_rows_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // clamp registers into their working ranges
  always_comb begin
    bpp_eff = {1'b0, bpp_q};
    if (bpp_eff == 4'd0) begin
      bpp_eff = 4'd1;
    end else if (bpp_eff > 4'(MaxPixelBytes)) begin
      bpp_eff = 4'(MaxPixelBytes);
    end
    rb_eff = CmpW'(row_bytes_q);
    if (rb_eff == '0) begin
      rb_eff = CmpW'(1);
    end else if (rb_eff > CmpW'(MaxRowBytes)) begin
      rb_eff = CmpW'(MaxRowBytes);
    end
  end

  // start of image folded in ahead of everything else
  assign soi      = item_i.start_of_image;
  assign col_v    = soi ? '0 : col_q;
  assign rows_v   = soi ? 16'd0 : rows_q;
  assign halt_v   = soi ? 1'b0 : halted_q;
  assign want_v   = soi | want_q;
  assign drop     = halt_v || (rows_v >= image_rows_q);
  assign col_next = CmpW'(col_v) + CmpW'(1);
  assign row_done = col_next >= rb_eff;
  assign rows_inc = rows_v + 16'd1;

  assign addr_o    = col_v;
  assign bpp_idx_o = BppIdxW'(bpp_eff - 4'd1);

  // next state and stage-1 handoff
  always_comb begin
    col_d    = col_q;
    want_d   = want_q;
    rows_d   = rows_q;
    filter_d = filter_q;
    halted_d = halted_q;
    issue_o  = 1'b0;
    rd_en_o  = 1'b0;
    tag_o.is_err    = 1'b0;
    tag_o.filter    = filter_q;
    tag_o.data      = item_i.stream_byte;
    tag_o.left_ok   = CmpW'(col_v) >= CmpW'(bpp_eff);
    tag_o.has_above = rows_v != 16'd0;
    tag_o.row_end   = 1'b0;
    tag_o.image_end = 1'b0;
    if (accept_i) begin
      col_d    = col_v;
      want_d   = want_v;
      rows_d   = rows_v;
      halted_d = halt_v;
      if (!drop) begin
        if (want_v) begin
          if (item_i.stream_byte > 8'(pngu_pkg::FLT_PAETH)) begin
            halted_d     = 1'b1;
            issue_o      = 1'b1;
            tag_o.is_err = 1'b1;
          end else begin
            filter_d = pngu_pkg::flt_e'(item_i.stream_byte[2:0]);
            want_d   = 1'b0;
            col_d    = '0;
          end
        end else begin
          issue_o = 1'b1;
          rd_en_o = 1'b1;
          if (row_done) begin
            tag_o.row_end   = 1'b1;
            tag_o.image_end = rows_inc == image_rows_q;
            rows_d          = rows_inc;
            want_d          = 1'b1;
            col_d           = '0;
          end else begin
            col_d = AddrW'(col_next);
          end
        end
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      want_q   <= 1'b1;
      rows_q   <= 16'd0;
      filter_q <= pngu_pkg::FLT_NONE;
      halted_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      want_q   <= want_d;
      rows_q   <= rows_d;
      filter_q <= filter_d;
      halted_q <= halted_d;
    end
  end

endmodule

FILE: rtl/pngu_recon.sv
// pngu_recon: reconstruction stage with pixel history, write-back and output register
// depends on pngu_pkg
module pngu_recon #(
  parameter int unsigned MaxPixelBytes = 4,
  parameter int unsigned AddrW         = 13,
  parameter int unsigned BppIdxW       = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  issue_i,
  input  pngu_pkg::tag_t        tag_i,
  input  logic [AddrW-1:0]      addr_i,
  input  logic [BppIdxW-1:0]    bpp_idx_i,
  input  logic [7:0]            rd_data_i,
  output logic                  wr_en_o,
  output logic [AddrW-1:0]      wr_addr_o,
  output logic [7:0]            wr_data_o,
  output logic                  busy_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output pngu_pkg::out_item_t   out_item_o
);

  logic                  s1_valid_q;
  pngu_pkg::tag_t        s1_tag_q;
  logic [AddrW-1:0]      s1_addr_q;
  logic [BppIdxW-1:0]    s1_bidx_q;
  logic                  out_valid_q;
  pngu_pkg::out_item_t   out_item_q;
  logic [7:0]            left_q  [MaxPixelBytes];
  logic [7:0]            upper_q [MaxPixelBytes];

  logic                  s1_adv;
  logic [7:0]            a;
  logic [7:0]            b;
  logic [7:0]            c;
  logic [8:0]            ab_sum;
  logic [7:0]            pred;
  logic [7:0]            recon;

  // stage 1 moves on whenever the output register is free or being taken
  assign s1_adv = s1_valid_q && !(out_valid_q && out_stall_i);
  assign busy_o = s1_valid_q && out_valid_q && out_stall_i;

  // predictor inputs
  assign b      = s1_tag_q.has_above ? rd_data_i : 8'd0;
  assign a      = s1_tag_q.left_ok ? left_q[s1_bidx_q] : 8'd0;
  assign c      = (s1_tag_q.left_ok && s1_tag_q.has_above) ? upper_q[s1_bidx_q] : 8'd0;
  assign ab_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (s1_tag_q.filter)
      pngu_pkg::FLT_SUB:   pred = a;
      pngu_pkg::FLT_UP:    pred = b;
      pngu_pkg::FLT_AVG:   pred = ab_sum[8:1];
      pngu_pkg::FLT_PAETH: pred = pngu_pkg::paeth(a, b, c);
      default:             pred = 8'd0;
    endcase
  end

  assign recon = s1_tag_q.data + pred;

  // write-back into the row memory
  assign wr_en_o   = s1_adv && !s1_tag_q.is_err;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = recon;

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (issue_i) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      s1_tag_q  <= tag_i;
      s1_addr_q <= addr_i;
      s1_bidx_q <= bpp_idx_i;
    end
  end

  // history of reconstructed and above-row bytes
  always_ff @(posedge clk_i) begin
    if (wr_en_o) begin
      for (int k = MaxPixelBytes - 1; k > 0; k--) begin
        left_q[k]  <= left_q[k-1];
        upper_q[k] <= upper_q[k-1];
      end
      left_q[0]  <= recon;
      upper_q[0] <= b;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q.pixel_byte <= s1_tag_q.is_err ? 8'd0 : recon;
      out_item_q.row_end    <= s1_tag_q.row_end;
      out_item_q.image_end  <= s1_tag_q.image_end;
      out_item_q.bad_filter <= s1_tag_q.is_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // an error item carries no pixel and no row marks
  a_err_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.bad_filter |->
      out_item_q.pixel_byte == 8'd0 && !out_item_q.row_end && !out_item_q.image_end)
    else $error("error item carries data");

  // the last byte of the image is also the last byte of its row
  a_img_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.image_end |-> out_item_q.row_end)
    else $error("image end without row end");

  // a new item only enters stage 1 when the previous one leaves
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_i |-> !s1_valid_q || s1_adv)
    else $error("stage 1 overrun");

  // a write-back is followed by a result on the output
  a_wr_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |=> out_valid_q && !out_item_q.bad_filter)
    else $error("write-back without result");

endmodule

FILE: rtl/png_scanline_unfilter_unit.sv
// png_scanline_unfilter_unit: png row reconstruction (none, sub, up, average, paeth)
// depends on pngu_pkg, pngu_ctrl, pngu_recon, pngu_row_mem
// path: an accepted data byte goes to the stage 1 register, then to the output register
// throughput: 1 byte per cycle while out_stall_i is low, set by the row memory read-modify-write
// legal filter bytes and dropped bytes give no result; an illegal filter byte gives an error item
// reset: asynchronous active low; control and config return to defaults, row memory is not cleared
module png_scanline_unfilter_unit #(
  parameter int unsigned MAX_ROW_BYTES   = 8192,
  parameter int unsigned MAX_PIXEL_BYTES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [pngu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  pngu_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output pngu_pkg::out_item_t           out_item_o
);

  localparam int unsigned AddrW   = $clog2(MAX_ROW_BYTES);
  localparam int unsigned BppIdxW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  logic                 accept;
  logic                 issue;
  logic                 rd_en;
  pngu_pkg::tag_t       tag;
  logic [AddrW-1:0]     addr;
  logic [BppIdxW-1:0]   bpp_idx;
  logic [7:0]           rd_data;
  logic                 wr_en;
  logic [AddrW-1:0]     wr_addr;
  logic [7:0]           wr_data;
  logic                 busy;

  // input handshake
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;

  pngu_ctrl #(
    .MaxRowBytes   (MAX_ROW_BYTES),
    .MaxPixelBytes (MAX_PIXEL_BYTES),
    .AddrW         (AddrW),
    .BppIdxW       (BppIdxW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .issue_o    (issue),
    .rd_en_o    (rd_en),
    .tag_o      (tag),
    .addr_o     (addr),
    .bpp_idx_o  (bpp_idx)
  );

  pngu_row_mem #(
    .Depth (MAX_ROW_BYTES),
    .AddrW (AddrW)
  ) u_row_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (addr),
    .rd_data_o (rd_data)
  );

  pngu_recon #(
    .MaxPixelBytes (MAX_PIXEL_BYTES),
    .AddrW         (AddrW),
    .BppIdxW       (BppIdxW)
  ) u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .tag_i       (tag),
    .addr_i      (addr),
    .bpp_idx_i   (bpp_idx),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: tb/sv/png_unfilter_check_pkg.sv
// png_unfilter_check_pkg: row reconstruction predictor and result checker for the unfilter tb
// depends on pngu_pkg for the item types, filter codes and register indexes
package png_unfilter_check_pkg;
  import pngu_pkg::*;

  localparam int unsigned RowMax   = 8192;
  localparam int unsigned PixelMax = 4;

  class row_rebuild_checker;
    // register copies
    logic [2:0]  bpp_reg;
    logic [13:0] row_bytes_reg;
    logic [15:0] rows_reg;

    // decoder state
    logic [7:0]  row_above [RowMax];
    logic [7:0]  left_hist [PixelMax];
    logic [7:0]  upper_hist [PixelMax];
    int unsigned column;
    bit          want_filter;
    logic [15:0] rows_done;
    flt_e        cur_filter;
    bit          halted;

    out_item_t   pending_pixels[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      foreach (row_above[i]) row_above[i] = 8'h00;
      clear_history();
      column        = 0;
      want_filter   = 1'b1;
      rows_done     = '0;
      cur_filter    = FLT_NONE;
      halted        = 1'b0;
      bpp_reg       = 3'd1;
      row_bytes_reg = 14'd1;
      rows_reg      = 16'd1;
      mismatches    = 0;
      results_seen  = 0;
    endfunction

    function void clear_history();
      foreach (left_hist[i]) begin
        left_hist[i]  = 8'h00;
        upper_hist[i] = 8'h00;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_BPP: begin
          bpp_reg = value[2:0];
        end
        CFG_ROW_BYTES: begin
          row_bytes_reg = value[13:0];
        end
        CFG_ROWS: begin
          rows_reg = value[15:0];
        end
        default: begin
        end
      endcase
    endfunction

    // nearest of left, above and upper-left to left + above - upper-left
    function logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      int est;
      int da;
      int db;
      int dc;
      est = int'(a) + int'(b) - int'(c);
      da  = est - int'(a);
      db  = est - int'(b);
      dc  = est - int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
    endfunction

    // one accepted item: update the decoder and queue the result it causes, if any
    function void rebuild_byte(in_item_t it);
      int unsigned bpp;
      int unsigned row_len;
      logic [7:0]  a;
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  v;
      logic [8:0]  pair_sum;
      bit          above;
      out_item_t   r;

      bpp     = (bpp_reg == 0) ? 1 : ((bpp_reg > PixelMax) ? PixelMax : bpp_reg);
      row_len = (row_bytes_reg == 0) ? 1 :
                ((row_bytes_reg > RowMax) ? RowMax : row_bytes_reg);

      // start of image restarts the row count and clears a halt
      if (it.start_of_image) begin
        rows_done   = '0;
        halted      = 1'b0;
        want_filter = 1'b1;
        column      = 0;
        clear_history();
      end

      if (halted || rows_done >= rows_reg) return;

      // filter byte at row start
      if (want_filter) begin
        if (it.stream_byte > 8'(FLT_PAETH)) begin
          halted       = 1'b1;
          r            = '0;
          r.bad_filter = 1'b1;
          pending_pixels.push_back(r);
          return;
        end
        cur_filter  = flt_e'(it.stream_byte[2:0]);
        want_filter = 1'b0;
        column      = 0;
        clear_history();
        return;
      end

      if (column >= RowMax) column = RowMax - 1;
      above = (rows_done != 0);
      a = (column >= bpp) ? left_hist[bpp-1] : 8'h00;
      b = above ? row_above[column] : 8'h00;
      c = (column >= bpp && above) ? upper_hist[bpp-1] : 8'h00;

      case (cur_filter)
        FLT_SUB: begin
          v = it.stream_byte + a;
        end
        FLT_UP: begin
          v = it.stream_byte + b;
        end
        FLT_AVG: begin
          pair_sum = {1'b0, a} + {1'b0, b};
          v = it.stream_byte + pair_sum[8:1];
        end
        FLT_PAETH: begin
          v = it.stream_byte + paeth_pick(a, b, c);
        end
        default: begin
          v = it.stream_byte;
        end
      endcase

      for (int k = PixelMax - 1; k > 0; k--) begin
        left_hist[k]  = left_hist[k-1];
        upper_hist[k] = upper_hist[k-1];
      end
      left_hist[0]      = v;
      upper_hist[0]     = b;
      row_above[column] = v;

      r            = '0;
      r.pixel_byte = v;
      if (column + 1 >= row_len) begin
        r.row_end   = 1'b1;
        rows_done   = rows_done + 16'd1;
        r.image_end = (rows_done == rows_reg);
        want_filter = 1'b1;
        column      = 0;
      end else begin
        column++;
      end
      pending_pixels.push_back(r);
    endfunction

    // one line per mismatch; printing stops after a while, counting does not
    task report_mismatch(string msg);
      if (mismatches < 40) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // compare an accepted result with the oldest expected one
    task match_pixel(out_item_t got);
      out_item_t want;
      results_seen++;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing expected: byte %02h ends %0b%0b bad %0b",
                                  results_seen, got.pixel_byte, got.row_end, got.image_end,
                                  got.bad_filter));
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_byte !== want.pixel_byte)
        report_mismatch($sformatf("result %0d pixel_byte %02h, expected %02h",
                                  results_seen, got.pixel_byte, want.pixel_byte));
      if (got.row_end !== want.row_end)
        report_mismatch($sformatf("result %0d row_end %0b, expected %0b",
                                  results_seen, got.row_end, want.row_end));
      if (got.image_end !== want.image_end)
        report_mismatch($sformatf("result %0d image_end %0b, expected %0b",
                                  results_seen, got.image_end, want.image_end));
      if (got.bad_filter !== want.bad_filter)
        report_mismatch($sformatf("result %0d bad_filter %0b, expected %0b",
                                  results_seen, got.bad_filter, want.bad_filter));
    endtask
  endclass

endpackage

FILE: tb/sv/tb_top.sv
// tb_top: drives png_scanline_unfilter_unit with directed and random scanline streams
// depends on pngu_pkg, png_unfilter_check_pkg and the unfilter rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pngu_pkg::*;
  import png_unfilter_check_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_item_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_item_o;

  row_rebuild_checker sb;
  bit                 idling;
  int unsigned        row_len;
  int unsigned        useful;
  int unsigned        stall_left;

  png_scanline_unfilter_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // receiver stalls: mostly short runs, a few long ones
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i = 1'b1;
    end else if (idling && $urandom_range(0, 99) < 20) begin
      stall_left  = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(7, 23);
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // handshake monitor: results first, then the accepted item, then register writes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.match_pixel(out_item_o);
      if (in_valid_i && !in_stall_o) sb.rebuild_byte(in_item_i);
      if (cfg_we_i) sb.set_reg(cfg_idx_i, cfg_data_i);
    end
  end

  // sender gap length
  function automatic int pick_pause();
    int roll;
    if (!idling) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // filtered data with extra weight on the extremes
  function automatic logic [7:0] pick_data();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 8'h00;
    if (roll < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // send one item; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] value, input logic soi);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item_i.stream_byte    = value;
    in_item_i.start_of_image = soi;
    in_valid_i               = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // hold the sender until every expected result is in, then let the pipe settle
  task automatic wait_drained();
    int spin;
    in_valid_i = 1'b0;
    spin = 0;
    while (sb.pending_pixels.size() != 0 && spin < 5000) begin
      @(negedge clk_i);
      spin++;
    end
    if (sb.pending_pixels.size() != 0) begin
      sb.report_mismatch($sformatf("%0d expected results never came",
                                   sb.pending_pixels.size()));
      sb.pending_pixels.delete();
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  // new settings between phases, with the effective row length kept for the generator
  task automatic configure(input logic [2:0] bpp, input logic [15:0] rb,
                           input logic [15:0] rows);
    wait_drained();
    write_reg(CFG_BPP, {13'd0, bpp});
    write_reg(CFG_ROW_BYTES, rb);
    write_reg(CFG_ROWS, rows);
    row_len = (rb[13:0] == 0) ? 1 : ((rb[13:0] > RowMax) ? RowMax : rb[13:0]);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // one image: filter byte then row_len data bytes per row; faults add bad filters,
  // cut rows and trailing bytes
  task automatic send_image(input int rows_n, input bit faults);
    int         n;
    logic [7:0] f;
    for (int r = 0; r < rows_n; r++) begin
      if (faults && $urandom_range(0, 99) < 4) begin
        f = 8'($urandom_range(5, 255));
        send_byte(f, r == 0);
        useful++;
        send_noise();
        return;
      end
      f = 8'($urandom_range(0, 4));
      send_byte(f, r == 0);
      useful++;
      n = row_len;
      if (faults && $urandom_range(0, 99) < 3) n = $urandom_range(0, row_len - 1);
      repeat (n) begin
        send_byte(pick_data(), 1'b0);
        useful++;
      end
      if (n < row_len) return;
    end
    if (faults && $urandom_range(0, 99) < 25) send_noise();
  endtask

  // stimulus
  initial begin : main
    logic [2:0]  bpp_pick;
    logic [15:0] rb_pick;
    logic [15:0] rows_pick;
    int          rows_n;
    int          roll;

    sb          = new();
    idling      = 1'b1;
    stall_left  = 0;
    row_len     = 1;
    useful      = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_BPP;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // every filter on a two byte row, with and without a row above
    configure(3'd1, 16'd2, 16'd2);
    send_byte(8'(FLT_NONE), 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'(FLT_SUB), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    // past the last row: dropped
    send_byte(8'hAB, 1'b0);
    // illegal filter, then a dropped byte while halted
    send_byte(8'h05, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'(FLT_UP), 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'(FLT_AVG), 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'(FLT_PAETH), 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'(FLT_PAETH), 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    // zero rows: everything dropped
    configure(3'd4, 16'd3, 16'd0);
    send_byte(8'(FLT_NONE), 1'b1);

    // row length shrinks under a row already past the new end
    configure(3'd2, 16'd4, 16'd2);
    send_byte(8'(FLT_SUB), 1'b1);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h30, 1'b0);
    wait_drained();
    write_reg(CFG_ROW_BYTES, 16'd2);
    row_len = 2;
    send_byte(8'h40, 1'b0);
    send_byte(8'(FLT_UP), 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);

    // register extremes: out of range low, pixel size above the limit, and
    // row length bits above the register width
    configure(3'd0, 16'd0, 16'hFFFF);
    send_image(6, 1'b0);
    idling = 1'b0;
    configure(3'd7, 16'hC009, 16'd2);
    send_image(2, 1'b0);
    idling = 1'b1;

    // random phases of well-formed images with faults mixed in
    useful = 0;
    while (useful < 800) begin
      roll     = $urandom_range(0, 99);
      bpp_pick = (roll < 85) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
      roll     = $urandom_range(0, 99);
      if (roll < 70) rb_pick = 16'($urandom_range(1, 8));
      else if (roll < 90) rb_pick = 16'($urandom_range(9, 40));
      else if (roll < 95) rb_pick = 16'd0;
      else rb_pick = 16'd1;
      roll = $urandom_range(0, 99);
      if (roll < 90) rows_pick = 16'($urandom_range(1, 5));
      else if (roll < 95) rows_pick = 16'hFFFF;
      else if (roll < 97) rows_pick = 16'd0;
      else rows_pick = 16'($urandom_range(6, 10));
      rows_n = (rows_pick == 0) ? 2 : ((rows_pick > 10) ? 3 : int'(rows_pick));
      idling = ($urandom_range(0, 99) < 80);
      configure(bpp_pick, rb_pick, rows_pick);
      repeat ($urandom_range(1, 3)) begin
        send_image(rows_n, 1'b1);
        if ($urandom_range(0, 99) < 15) wait_drained();
      end
    end

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
